/* hdl/sfp_pkg.sv */
// Shared types and constants of the segment allocator.
`default_nettype none

package sfp_pkg;

  localparam int FIELD_W    = 16;
  localparam int STATUS_W   = 3;
  localparam int ACT_W      = 2;
  localparam int POL_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_CREATE,
    ACT_DELETE,
    ACT_RELEASE,
    ACT_COMPACT
  } act_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK,
    STS_NEED_COMPACT,
    STS_NO_MEMORY,
    STS_NOT_OWNER,
    STS_NO_SEGMENT,
    STS_NONE_REMOVED
  } status_e;

  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MEMORY_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 1'b1;

  localparam logic [FIELD_W-1:0] MEM_SIZE_RESET = 16'd4096;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_CFIN,
    S_DEL,
    S_REL,
    S_CMP,
    S_SORT
  } state_e;

  // Per-cell command for one cycle.
  typedef struct packed {
    logic ld_new;
    logic ld_left;
    logic ld_right;
    logic set_base;
    logic clr;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* hdl/sfp_if.sv */
// Request and response channel interfaces of the segment allocator.
`default_nettype none

interface sfp_req_if;
  logic                        valid;
  logic                        ready;
  logic [sfp_pkg::ACT_W-1:0]   action;
  logic [sfp_pkg::FIELD_W-1:0] owner;
  logic [sfp_pkg::FIELD_W-1:0] request_size;
  logic [sfp_pkg::FIELD_W-1:0] target_id;

  modport source (output valid, action, owner, request_size, target_id, input ready);
  modport sink (input valid, action, owner, request_size, target_id, output ready);
endinterface

interface sfp_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sfp_pkg::STATUS_W-1:0] status;
  logic [sfp_pkg::FIELD_W-1:0]  segment_id;
  logic [sfp_pkg::FIELD_W-1:0]  base_address;
  logic                         last;

  modport source (output valid, status, segment_id, base_address, last, input ready);
  modport sink (input valid, status, segment_id, base_address, last, output ready);
endinterface

`default_nettype wire

/* hdl/segment_allocator_fit_policy.sv */
// Segment allocator top level: a sorted chain of entry cells and its sequencer.
// Create walks the live segments and the tail gap in address order, then answers; delete and
// release answer directly, compact returns one word per live segment (one when empty); a full output holds each answer.
// Every request ends with rounds of neighbor exchange that re-sort the chain.
// One request is in flight at a time; the result register lets the next start meanwhile.
// Reset (async, active low) empties the table, zeroes the id counter, restores config.
`default_nettype none

module segment_allocator_fit_policy #(
  parameter int MAX_SEGMENTS = 16,
  parameter int ADDR_BITS    = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [sfp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire  [sfp_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  sfp_req_if.sink                          req_i,
  sfp_rsp_if.source                        rsp_o
);
  import sfp_pkg::*;

  localparam int N   = MAX_SEGMENTS;
  localparam int AW  = ADDR_BITS;
  localparam int IW  = $clog2(N);
  localparam int KW  = $clog2(N + 1);
  // The walk cursor must hold a base plus a full length without wrapping.
  localparam int CW  = ((AW > FIELD_W) ? AW : FIELD_W) + 1;
  // Sum of up to N lengths.
  localparam int UW  = FIELD_W + KW;
  localparam int LEN_LSB  = IW;
  localparam int BASE_LSB = IW + FIELD_W;
  localparam int ID_LSB   = BASE_LSB + AW;
  localparam int OWN_LSB  = ID_LSB + FIELD_W;
  localparam int EW       = OWN_LSB + FIELD_W + 1;

  // Cell outputs, unpacked.
  logic [EW-1:0]      ent [N];
  logic [N-1:0]       ooo;
  logic [N-1:0]       c_v;
  logic [FIELD_W-1:0] c_own [N];
  logic [FIELD_W-1:0] c_id [N];
  logic [AW-1:0]      c_base [N];
  logic [FIELD_W-1:0] c_len [N];
  logic [IW-1:0]      c_idx [N];
  cell_ctl_t          ctl [N];
  logic [EW-1:0]      new_ent;

  state_e state_q, state_d;
  logic [FIELD_W-1:0] mem_q;
  logic [POL_W-1:0]   pol_q;
  logic [FIELD_W-1:0] own_q, own_d, rsz_q, rsz_d, tid_q, tid_d;
  logic [KW-1:0]      kc_q, kc_d, sc_q, sc_d;
  logic [CW-1:0]      cur_q, cur_d, pick_q, pick_d, plen_q, plen_d;
  logic [UW-1:0]      used_q, used_d;
  logic               found_q, found_d;
  logic [FIELD_W-1:0] nid_q, nid_d;

  logic               rsp_valid_q, rsp_load, out_free;
  logic [STATUS_W-1:0] rsp_status_q, rsp_status_d;
  logic [FIELD_W-1:0] rsp_id_q, rsp_id_d, rsp_base_q, rsp_base_d;
  logic               rsp_last_q, rsp_last_d;
  logic               req_acc;

  genvar g;
  for (g = 0; g < N; g++) begin : g_cells
    logic [EW-1:0] left_ent, right_ent;
    if (g == 0) begin : g_first
      assign left_ent = '0;
    end else begin : g_mid_l
      assign left_ent = ent[g-1];
    end
    if (g == N - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_mid_r
      assign right_ent = ent[g+1];
    end

    sfp_cell #(.AW(AW), .IW(IW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl[g]),
      .left_i  (left_ent),
      .right_i (right_ent),
      .new_i   (new_ent),
      .ent_o   (ent[g]),
      .ooo_o   (ooo[g])
    );

    assign c_v[g]    = ent[g][EW-1];
    assign c_own[g]  = ent[g][OWN_LSB+FIELD_W-1:OWN_LSB];
    assign c_id[g]   = ent[g][ID_LSB+FIELD_W-1:ID_LSB];
    assign c_base[g] = ent[g][BASE_LSB+AW-1:BASE_LSB];
    assign c_len[g]  = ent[g][LEN_LSB+FIELD_W-1:LEN_LSB];
    assign c_idx[g]  = ent[g][IW-1:0];
  end

  // Lowest free table index, used for the entry of a new segment.
  logic [N-1:0]  free_idx;
  logic [IW-1:0] slot;
  always_comb begin
    free_idx = '1;
    slot     = '0;
    for (int i = 0; i < N; i++) begin
      for (int k = 0; k < N; k++) begin
        if (c_v[k] && (c_idx[k] == IW'(i))) free_idx[i] = 1'b0;
      end
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (free_idx[i]) slot = IW'(i);
    end
  end

  // Delete lookup: the matching segment with the lowest table index wins.
  logic [N-1:0]       dmatch, dhit, dsel;
  logic [IW-1:0]      dlo;
  logic               dany;
  logic [FIELD_W-1:0] dsel_own;
  logic [AW-1:0]      dsel_base;
  always_comb begin
    dhit      = '0;
    dlo       = '0;
    dsel      = '0;
    dsel_own  = '0;
    dsel_base = '0;
    for (int k = 0; k < N; k++) begin
      dmatch[k] = c_v[k] && (c_id[k] == tid_q);
    end
    for (int i = 0; i < N; i++) begin
      for (int k = 0; k < N; k++) begin
        if (dmatch[k] && (c_idx[k] == IW'(i))) dhit[i] = 1'b1;
      end
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (dhit[i]) dlo = IW'(i);
    end
    for (int k = 0; k < N; k++) begin
      dsel[k] = dmatch[k] && (c_idx[k] == dlo);
      if (dsel[k]) begin
        dsel_own  = dsel_own | c_own[k];
        dsel_base = dsel_base | c_base[k];
      end
    end
    dany = |dmatch;
  end

  // Release: every live segment of the requesting owner.
  logic [N-1:0] rmatch;
  always_comb begin
    for (int k = 0; k < N; k++) begin
      rmatch[k] = c_v[k] && (c_own[k] == own_q);
    end
  end

  // The cell under the walk pointer.
  logic [IW-1:0]      ki;
  logic               at_tail, nxt_v;
  logic [CW-1:0]      wbase, wmem, wend, glen, segend;
  logic [FIELD_W-1:0] wlen;
  logic               fits, take;
  assign ki      = (kc_q < KW'(N)) ? kc_q[IW-1:0] : '0;
  assign at_tail = (kc_q == KW'(N)) || !c_v[ki];
  assign nxt_v   = (ki == IW'(N - 1)) ? 1'b0 : c_v[IW'(ki + 1'b1)];
  assign wbase   = CW'(c_base[ki]);
  assign wlen    = c_len[ki];
  assign wmem    = CW'(mem_q);
  assign wend    = at_tail ? wmem : ((wbase < wmem) ? wbase : wmem);
  assign glen    = (wend > cur_q) ? (wend - cur_q) : '0;
  assign fits    = (cur_q <= wmem) && (glen >= CW'(rsz_q));
  assign take    = fits && (!found_q || ((pol_q == POL_BEST) && (glen < plen_q)) ||
                   ((pol_q == POL_WORST) && (glen > plen_q)));
  assign segend  = wbase + CW'(wlen);

  // Free bytes if nothing fits: memory size minus all live lengths.
  logic [UW-1:0] wmem_u, freeb;
  assign wmem_u = UW'(mem_q);
  assign freeb  = (wmem_u > used_q) ? (wmem_u - used_q) : '0;

  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  always_comb begin
    state_d      = state_q;
    own_d        = own_q;
    rsz_d        = rsz_q;
    tid_d        = tid_q;
    kc_d         = kc_q;
    sc_d         = sc_q;
    cur_d        = cur_q;
    used_d       = used_q;
    found_d      = found_q;
    pick_d       = pick_q;
    plen_d       = plen_q;
    nid_d        = nid_q;
    rsp_load     = 1'b0;
    rsp_status_d = STS_OK;
    rsp_id_d     = '0;
    rsp_base_d   = '0;
    rsp_last_d   = 1'b1;
    new_ent      = '0;
    for (int k = 0; k < N; k++) ctl[k] = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          own_d   = req_i.owner;
          rsz_d   = req_i.request_size;
          tid_d   = req_i.target_id;
          kc_d    = '0;
          sc_d    = '0;
          cur_d   = '0;
          used_d  = '0;
          found_d = 1'b0;
          unique case (act_e'(req_i.action))
            ACT_CREATE:  state_d = S_WALK;
            ACT_DELETE:  state_d = S_DEL;
            ACT_RELEASE: state_d = S_REL;
            ACT_COMPACT: state_d = S_CMP;
            default:     state_d = S_CMP;
          endcase
        end
      end

      // One gap per cycle in address order; the tail gap closes the walk.
      S_WALK: begin
        if (take) begin
          found_d = 1'b1;
          pick_d  = cur_q;
          plen_d  = glen;
        end
        if (at_tail) begin
          state_d = S_CFIN;
        end else begin
          cur_d  = (segend > cur_q) ? segend : cur_q;
          used_d = used_q + UW'(wlen);
          kc_d   = kc_q + 1'b1;
        end
      end

      S_CFIN: begin
        if (out_free) begin
          rsp_load = 1'b1;
          if (c_v[N-1]) begin
            rsp_status_d = STS_NO_MEMORY;
          end else if (!found_q) begin
            rsp_status_d = (freeb >= UW'(rsz_q)) ? STS_NEED_COMPACT : STS_NO_MEMORY;
          end else begin
            rsp_id_d   = nid_q;
            rsp_base_d = pick_q[FIELD_W-1:0];
            nid_d      = nid_q + 1'b1;
            // The last cell is free whenever the table is not full.
            new_ent = {1'b1, own_q, nid_q, pick_q[AW-1:0], rsz_q, slot};
            ctl[N-1].ld_new = 1'b1;
          end
          state_d = S_SORT;
        end
      end

      S_DEL: begin
        if (out_free) begin
          rsp_load = 1'b1;
          rsp_id_d = tid_q;
          if (!dany) begin
            rsp_status_d = STS_NO_SEGMENT;
          end else if (dsel_own != own_q) begin
            rsp_status_d = STS_NOT_OWNER;
          end else begin
            rsp_base_d = FIELD_W'(dsel_base);
            for (int k = 0; k < N; k++) ctl[k].clr = dsel[k];
          end
          state_d = S_SORT;
        end
      end

      S_REL: begin
        if (out_free) begin
          rsp_load     = 1'b1;
          rsp_status_d = (|rmatch) ? STS_OK : STS_NONE_REMOVED;
          for (int k = 0; k < N; k++) ctl[k].clr = rmatch[k];
          state_d = S_SORT;
        end
      end

      // Cells are in address order, so packing walks them front to back.
      S_CMP: begin
        if (out_free) begin
          rsp_load = 1'b1;
          if (!c_v[ki]) begin
            state_d = S_SORT;
          end else begin
            rsp_id_d   = c_id[ki];
            rsp_base_d = FIELD_W'(cur_q[AW-1:0]);
            rsp_last_d = !nxt_v;
            new_ent[BASE_LSB+AW-1:BASE_LSB] = cur_q[AW-1:0];
            ctl[ki].set_base = 1'b1;
            cur_d = cur_q + CW'(c_len[ki]);
            kc_d  = kc_q + 1'b1;
            if (!nxt_v) state_d = S_SORT;
          end
        end
      end

      // Odd-even exchange between neighbors; N rounds restore full order.
      S_SORT: begin
        for (int k = 0; k < N - 1; k++) begin
          if ((((k % 2) == 1) == sc_q[0]) && ooo[k]) begin
            ctl[k].ld_right  = 1'b1;
            ctl[k+1].ld_left = 1'b1;
          end
        end
        sc_d = sc_q + 1'b1;
        if (sc_q == KW'(N - 1)) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mem_q       <= MEM_SIZE_RESET;
      pol_q       <= POL_FIRST;
      nid_q       <= '0;
      rsp_valid_q <= 1'b0;
      kc_q        <= '0;
      sc_q        <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      nid_q   <= nid_d;
      kc_q    <= kc_d;
      sc_q    <= sc_d;
      found_q <= found_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MEMORY_SIZE: mem_q <= cfg_wdata_i;
          REG_FIT_POLICY:  pol_q <= cfg_wdata_i[POL_W-1:0];
          default:         mem_q <= mem_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    own_q  <= own_d;
    rsz_q  <= rsz_d;
    tid_q  <= tid_d;
    cur_q  <= cur_d;
    used_q <= used_d;
    pick_q <= pick_d;
    plen_q <= plen_d;
    if (rsp_load) begin
      rsp_status_q <= rsp_status_d;
      rsp_id_q     <= rsp_id_d;
      rsp_base_q   <= rsp_base_d;
      rsp_last_q   <= rsp_last_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.segment_id   = rsp_id_q;
  assign rsp_o.base_address = rsp_base_q;
  assign rsp_o.last         = rsp_last_q;

endmodule

`default_nettype wire

/* hdl/sfp_cell.sv */
// One table cell: holds a segment entry and trades it with its neighbors.
`default_nettype none

module sfp_cell #(
  parameter int AW = 16,
  parameter int IW = 4,
  localparam int BASE_LSB = IW + sfp_pkg::FIELD_W,
  localparam int EW       = BASE_LSB + AW + 2 * sfp_pkg::FIELD_W + 1
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  sfp_pkg::cell_ctl_t   ctl_i,
  input  wire  [EW-1:0]        left_i,
  input  wire  [EW-1:0]        right_i,
  input  wire  [EW-1:0]        new_i,
  output logic [EW-1:0]        ent_o,
  output logic                 ooo_o
);
  import sfp_pkg::*;

  logic          v_q;
  logic [EW-2:0] pay_q;
  logic [AW+IW-1:0] key, rkey;
  logic          rv;

  assign ent_o = {v_q, pay_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      priority if (ctl_i.ld_new) begin
        v_q <= new_i[EW-1];
      end else if (ctl_i.ld_left) begin
        v_q <= left_i[EW-1];
      end else if (ctl_i.ld_right) begin
        v_q <= right_i[EW-1];
      end else if (ctl_i.clr) begin
        v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (ctl_i.ld_new) begin
      pay_q <= new_i[EW-2:0];
    end else if (ctl_i.ld_left) begin
      pay_q <= left_i[EW-2:0];
    end else if (ctl_i.ld_right) begin
      pay_q <= right_i[EW-2:0];
    end else if (ctl_i.set_base) begin
      pay_q[BASE_LSB+AW-1:BASE_LSB] <= new_i[BASE_LSB+AW-1:BASE_LSB];
    end
  end

  // Order is valid first, then ascending base, then ascending table index.
  assign key  = {pay_q[BASE_LSB+AW-1:BASE_LSB], pay_q[IW-1:0]};
  assign rkey = {right_i[BASE_LSB+AW-1:BASE_LSB], right_i[IW-1:0]};
  assign rv   = right_i[EW-1];
  assign ooo_o = (!v_q && rv) || (v_q && rv && (key > rkey));

endmodule

`default_nettype wire

/* hdl/sfp_checker.sv */
// Port-level checker of the segment allocator and its bind.
`default_nettype none

module sfp_checker (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            in_valid,
  input wire                            in_ready,
  input wire                            out_valid,
  input wire                            out_ready,
  input wire [sfp_pkg::STATUS_W-1:0]    out_status,
  input wire [sfp_pkg::FIELD_W-1:0]     out_id,
  input wire [sfp_pkg::FIELD_W-1:0]     out_base,
  input wire                            out_last
);
  import sfp_pkg::*;

  // A stalled result word holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_id) &&
    $stable(out_base) && $stable(out_last))
    else $error("result word changed while stalled");

  // One request at a time: after an accept the block is busy.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // A compact sequence is not finished, so no new request may enter.
  a_mid_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_last |-> !in_ready)
    else $error("ready during a multi-word result");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_status <= STATUS_W'(STS_NONE_REMOVED)))
    else $error("undefined status code");

endmodule

bind segment_allocator_fit_policy sfp_checker u_sfp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (req_i.valid),
  .in_ready   (req_i.ready),
  .out_valid  (rsp_o.valid),
  .out_ready  (rsp_o.ready),
  .out_status (rsp_o.status),
  .out_id     (rsp_o.segment_id),
  .out_base   (rsp_o.base_address),
  .out_last   (rsp_o.last)
);

`default_nettype wire

/* verif/segment_allocator_fit_policy_tb.sv */
// Self-checking testbench of the segment allocator: directed table, then random requests.
`default_nettype none

module segment_allocator_fit_policy_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfp_pkg::*;

  localparam int NSEG = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  // A result word as the block should return it.
  typedef struct {
    status_e           status;
    logic [15:0]       seg_id;
    logic [15:0]       base;
    logic              last;
  } rsp_word_t;

  // One row of the directed table. When has_exp is set, the single result
  // typed into the row is checked against the predictor as well.
  typedef struct {
    act_e        action;
    logic [15:0] owner;
    logic [15:0] size;
    logic [15:0] tid;
    logic        has_exp;
    status_e     exp_status;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  sfp_req_if req_if ();
  sfp_rsp_if rsp_if ();

  segment_allocator_fit_policy DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // The predictor's private picture of the segment table and registers.
  logic        tbl_valid [NSEG];
  logic [15:0] tbl_owner [NSEG];
  logic [15:0] tbl_id [NSEG];
  logic [15:0] tbl_base [NSEG];
  logic [15:0] tbl_len [NSEG];
  logic [15:0] id_counter;
  logic [15:0] mem_bytes;
  logic [1:0]  policy;

  rsp_word_t pending_rsp[$];
  int errors = 0;
  int idle_cycles = 0;
  bit rsp_hold = 1'b0;     // long receiver hold-off requested

  // Live entries in ascending base order, ties by lower index.
  function automatic int order_by_base(output int ord[NSEG]);
    int n;
    int j;
    n = 0;
    for (int i = 0; i < NSEG; i++) begin
      if (tbl_valid[i]) begin
        j = n;
        while (j > 0 && tbl_base[ord[j-1]] > tbl_base[i]) begin
          ord[j] = ord[j-1];
          j--;
        end
        ord[j] = i;
        n++;
      end
    end
    return n;
  endfunction

  function automatic void push_word(status_e st, logic [15:0] id, logic [15:0] b, logic l);
    rsp_word_t w;
    w.status = st;
    w.seg_id = id;
    w.base = b;
    w.last = l;
    pending_rsp.push_back(w);
  endfunction

  // Updates the table for one request and queues the words it produces.
  function automatic void predict_request(act_e act, logic [15:0] own, logic [15:0] sz,
                                          logic [15:0] tid);
    int ord[NSEG];
    int n;
    int slot;
    int e;
    longint cursor;
    longint used;
    longint gap_end;
    longint gap_len;
    longint pick_base;
    longint pick_len;
    bit found;
    bit take;
    bit any;
    slot = -1;
    case (act)
      ACT_CREATE: begin
        for (int i = NSEG - 1; i >= 0; i--) if (!tbl_valid[i]) slot = i;
        if (slot < 0) begin
          push_word(STS_NO_MEMORY, '0, '0, 1'b1);
          return;
        end
        n = order_by_base(ord);
        cursor = 0;
        used = 0;
        found = 1'b0;
        pick_base = 0;
        pick_len = 0;
        for (int k = 0; k <= n; k++) begin
          if (k < n) gap_end = (tbl_base[ord[k]] < mem_bytes) ? tbl_base[ord[k]] : mem_bytes;
          else gap_end = mem_bytes;
          gap_len = (gap_end > cursor) ? gap_end - cursor : 0;
          if (cursor <= mem_bytes && gap_len >= sz) begin
            if (!found) take = 1'b1;
            else if (policy == POL_BEST) take = gap_len < pick_len;
            else if (policy == POL_WORST) take = gap_len > pick_len;
            else take = 1'b0;
            if (take) begin
              found = 1'b1;
              pick_base = cursor;
              pick_len = gap_len;
            end
          end
          if (k < n) begin
            e = ord[k];
            if (longint'(tbl_base[e]) + tbl_len[e] > cursor)
              cursor = longint'(tbl_base[e]) + tbl_len[e];
            used += tbl_len[e];
          end
        end
        if (!found) begin
          push_word(((mem_bytes > used ? mem_bytes - used : 0) >= sz) ? STS_NEED_COMPACT
                    : STS_NO_MEMORY, '0, '0, 1'b1);
          return;
        end
        tbl_valid[slot] = 1'b1;
        tbl_owner[slot] = own;
        tbl_id[slot] = id_counter;
        tbl_base[slot] = pick_base[15:0];
        tbl_len[slot] = sz;
        push_word(STS_OK, id_counter, pick_base[15:0], 1'b1);
        id_counter++;
      end
      ACT_DELETE: begin
        for (int i = 0; i < NSEG; i++) begin
          if (tbl_valid[i] && tbl_id[i] == tid) begin
            if (tbl_owner[i] != own) begin
              push_word(STS_NOT_OWNER, tid, '0, 1'b1);
            end else begin
              tbl_valid[i] = 1'b0;
              push_word(STS_OK, tid, tbl_base[i], 1'b1);
            end
            return;
          end
        end
        push_word(STS_NO_SEGMENT, tid, '0, 1'b1);
      end
      ACT_RELEASE: begin
        any = 1'b0;
        for (int i = 0; i < NSEG; i++) begin
          if (tbl_valid[i] && tbl_owner[i] == own) begin
            tbl_valid[i] = 1'b0;
            any = 1'b1;
          end
        end
        push_word(any ? STS_OK : STS_NONE_REMOVED, '0, '0, 1'b1);
      end
      default: begin
        n = order_by_base(ord);
        if (n == 0) begin
          push_word(STS_OK, '0, '0, 1'b1);
          return;
        end
        cursor = 0;
        for (int k = 0; k < n; k++) begin
          e = ord[k];
          tbl_base[e] = cursor[15:0];
          push_word(STS_OK, tbl_id[e], tbl_base[e], k == n - 1);
          cursor += tbl_len[e];
        end
      end
    endcase
  endfunction

  // Sender: drives one request word and waits for its handshake. With no gap,
  // valid stays high and the new word replaces the one just taken.
  task automatic send_request(act_e act, logic [15:0] own, logic [15:0] sz, logic [15:0] tid,
                              int gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.action <= act;
    req_if.owner <= own;
    req_if.request_size <= sz;
    req_if.target_id <= tid;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    // The word was taken at this edge; predict it now, in issue order.
    predict_request(act, own, sz, tid);
  endtask

  // Stops offering words, then waits until every expected word has arrived,
  // plus a margin for re-sorting.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (3 * NSEG) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MEMORY_SIZE) mem_bytes = val;
    else policy = val[1:0];
    @(posedge clk_i);
  endtask

  // Random request biased toward creates of small sizes with live ids, so the
  // table fills, fragments and compacts often.
  task automatic random_request(int gap_max);
    int pick;
    logic [15:0] own;
    logic [15:0] sz;
    logic [15:0] tid;
    pick = $urandom_range(0, 99);
    own = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    sz = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, mem_bytes / 6));
    tid = ($urandom_range(0, 4) == 0) ? 16'($urandom)
          : 16'(id_counter - 16'($urandom_range(1, 20)));
    if (pick < 50) send_request(ACT_CREATE, own, sz, tid, $urandom_range(0, gap_max));
    else if (pick < 75) send_request(ACT_DELETE, own, sz, tid, $urandom_range(0, gap_max));
    else if (pick < 87) send_request(ACT_RELEASE, own, sz, tid, $urandom_range(0, gap_max));
    else send_request(ACT_COMPACT, own, sz, tid, $urandom_range(0, gap_max));
  endtask

  // Receiver: random stalls per word, with a long hold-off on request.
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rsp_hold) begin
        rsp_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        rsp_hold = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
    end
  end

  // Checker: compares each accepted response word with the oldest expectation.
  always @(posedge clk_i) begin
    rsp_word_t w;
    if (rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected word status=%0d id=%0d base=%0d last=%0d", $realtime,
                 rsp_if.status, rsp_if.segment_id, rsp_if.base_address, rsp_if.last);
        errors++;
      end else begin
        w = pending_rsp.pop_front();
        if (rsp_if.status !== w.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, w.status, rsp_if.status);
          errors++;
        end
        if (rsp_if.segment_id !== w.seg_id) begin
          $display("%0t: segment_id expected %0d actual %0d", $realtime, w.seg_id,
                   rsp_if.segment_id);
          errors++;
        end
        if (rsp_if.base_address !== w.base) begin
          $display("%0t: base_address expected %0d actual %0d", $realtime, w.base,
                   rsp_if.base_address);
          errors++;
        end
        if (rsp_if.last !== w.last) begin
          $display("%0t: last expected %0d actual %0d", $realtime, w.last, rsp_if.last);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on either channel.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d words outstanding", $realtime, pending_rsp.size());
      $display("segment_allocator_fit_policy_tb: done, errors");
      $finish;
    end
  end

  // Directed rows: reset behavior, field extremes, every action and every status.
  dir_row_t dir_rows[] = '{
    '{ACT_COMPACT, 16'd0, 16'd0, 16'd0, 1'b1, STS_OK},              // empty compact
    '{ACT_RELEASE, 16'd7, 16'd0, 16'd0, 1'b1, STS_NONE_REMOVED},
    '{ACT_DELETE, 16'd0, 16'd0, 16'd0, 1'b1, STS_NO_SEGMENT},
    '{ACT_DELETE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, STS_NO_SEGMENT},
    '{ACT_CREATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, STS_NO_MEMORY},
    '{ACT_CREATE, 16'd1, 16'd0, 16'd0, 1'b1, STS_OK},               // empty segment
    '{ACT_CREATE, 16'd1, 16'd1000, 16'd0, 1'b1, STS_OK},
    '{ACT_CREATE, 16'd2, 16'd500, 16'd0, 1'b0, STS_OK},
    '{ACT_CREATE, 16'd3, 16'd1000, 16'd0, 1'b0, STS_OK},
    '{ACT_CREATE, 16'd2, 16'd300, 16'd0, 1'b0, STS_OK},
    '{ACT_DELETE, 16'd9, 16'd0, 16'd2, 1'b1, STS_NOT_OWNER},
    '{ACT_DELETE, 16'd2, 16'd0, 16'd2, 1'b1, STS_OK},
    '{ACT_DELETE, 16'd2, 16'd0, 16'd2, 1'b1, STS_NO_SEGMENT},
    '{ACT_CREATE, 16'd4, 16'd500, 16'd0, 1'b0, STS_OK},             // exact fit
    '{ACT_CREATE, 16'd4, 16'd1000, 16'd0, 1'b0, STS_OK},            // small tail gap left
    '{ACT_DELETE, 16'd3, 16'd0, 16'd3, 1'b0, STS_OK},
    '{ACT_CREATE, 16'd5, 16'd1200, 16'd0, 1'b1, STS_NEED_COMPACT},
    '{ACT_COMPACT, 16'd0, 16'd0, 16'd0, 1'b0, STS_OK},
    '{ACT_CREATE, 16'd5, 16'd1296, 16'd0, 1'b0, STS_OK},            // tail exact fit
    '{ACT_RELEASE, 16'd4, 16'd0, 16'd0, 1'b1, STS_OK},
    '{ACT_RELEASE, 16'd1, 16'd0, 16'd0, 1'b1, STS_OK},
    '{ACT_COMPACT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, STS_OK}
  };

  // Main sequence: directed table, then random phases over several settings.
  initial begin
    logic [15:0] sizes[5];
    logic [1:0] pols[5];
    req_if.valid = 1'b0;
    req_if.action = ACT_CREATE;
    req_if.owner = '0;
    req_if.request_size = '0;
    req_if.target_id = '0;
    for (int i = 0; i < NSEG; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_owner[i] = '0;
      tbl_id[i] = '0;
      tbl_base[i] = '0;
      tbl_len[i] = '0;
    end
    id_counter = '0;
    mem_bytes = MEM_SIZE_RESET;
    policy = POL_FIRST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      send_request(dir_rows[r].action, dir_rows[r].owner, dir_rows[r].size, dir_rows[r].tid,
                   $urandom_range(0, 14));
      // The typed-in status must agree with the predictor for this row.
      if (dir_rows[r].has_exp && pending_rsp[$].status != dir_rows[r].exp_status) begin
        $display("%0t: row %0d status expected %0d predicted %0d", $realtime, r,
                 dir_rows[r].exp_status, pending_rsp[$].status);
        errors++;
      end
    end
    drain();

    // Random phases. Each phase sets both registers while the block is idle.
    sizes = '{16'd4096, 16'd1, 16'd65535, 16'd300, 16'd2000};
    pols = '{POL_BEST, POL_WORST, POL_FIRST, 2'd3, POL_BEST};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_MEMORY_SIZE, sizes[ph]);
      write_reg(REG_FIT_POLICY, 16'(pols[ph]));
      if (ph == 1) begin
        // Long receiver hold-off while requests keep coming back to back.
        rsp_hold = 1'b1;
        for (int i = 0; i < 8; i++) random_request(0);
      end
      for (int i = 0; i < 18; i++) random_request(($urandom_range(0, 2) == 0) ? 0 : 14);
      // Sender pause: wait for every outstanding word before the next phase.
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("segment_allocator_fit_policy_tb: done, clean");
    end else begin
      $display("segment_allocator_fit_policy_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
